[rtl/lmsd_pkg.sv]
// ----------------------------------------------------------------------------
// lmsd_pkg
// Shared types and constants of the LED matrix scan dimmer.
// ----------------------------------------------------------------------------
package lmsd_pkg;

  localparam int ROWS   = 4;
  localparam int COLS   = 6;
  localparam int LEVELS = 3;

  localparam int ROW_IW   = $clog2(ROWS);
  localparam int ROW_W    = $clog2(ROWS + 1);
  localparam int SLICE_IW = $clog2(LEVELS);
  localparam int SHIFT_W  = $clog2(COLS + 1);
  localparam int TGT_W    = 16;
  localparam int SUM_W    = 18;

  localparam logic [TGT_W-1:0] SLICE0_RST = 16'd10;
  localparam logic [TGT_W-1:0] SLICE1_RST = 16'd300;
  localparam logic [TGT_W-1:0] SLICE2_RST = 16'd2000;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SLICE0 = 2'd0,
    REG_SLICE1 = 2'd1,
    REG_SLICE2 = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_ROWCLK     = 3'd0,
    PH_SHIFT      = 3'd1,
    PH_LATCH      = 3'd2,
    PH_WAIT       = 3'd3,
    PH_BLANKCLK   = 3'd4,
    PH_BLANKLATCH = 3'd5
  } phase_t;

  // pin word, row_data in the lowest bit
  typedef struct packed {
    logic clear_pulse;
    logic latch_pulse;
    logic col_clock_pulse;
    logic col_data;
    logic row_clock_pulse;
    logic row_data;
  } pins_t;

endpackage

[rtl/led_matrix_scan_dimmer.sv]
// ----------------------------------------------------------------------------
// led_matrix_scan_dimmer
// Scan sequencer and pixel store for a 4x6 LED matrix with 3 brightness slices.
// ----------------------------------------------------------------------------
// The pin word of an input word (draw, clear or scan tick), if any, goes into
// the output register, or the skid register while that one is held. The scan
// sequencer and pixel store update in a single register stage; a two-word
// output buffer (output register plus skid register) holds results, so
// in_tready only drops while both buffer words are occupied. Sustained rate is
// one word per cycle whenever the output side keeps up.
module led_matrix_scan_dimmer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // pixel_x[2:0], pixel_y[4:3], pixel_level[6:5], zero[7]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  // pin words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // row_data[0], row_clock_pulse[1], col_data[2],
                                  // col_clock_pulse[3], latch_pulse[4], clear_pulse[5],
                                  // zero[7:6]
);

  localparam int ROWS     = lmsd_pkg::ROWS;
  localparam int COLS     = lmsd_pkg::COLS;
  localparam int LEVELS   = lmsd_pkg::LEVELS;
  localparam int ROW_IW   = lmsd_pkg::ROW_IW;
  localparam int ROW_W    = lmsd_pkg::ROW_W;
  localparam int SLICE_IW = lmsd_pkg::SLICE_IW;
  localparam int SHIFT_W  = lmsd_pkg::SHIFT_W;
  localparam int TGT_W    = lmsd_pkg::TGT_W;
  localparam int SUM_W    = lmsd_pkg::SUM_W;

  // configuration
  logic [TGT_W-1:0] target_r [LEVELS];

  // pixel store
  logic [COLS-1:0] row_bits_r    [ROWS];
  logic [COLS-1:0] slice_masks_r [ROWS][LEVELS];

  // scan state
  lmsd_pkg::phase_t    phase_r, phase_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [SLICE_IW-1:0] slice_r, slice_nxt;
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [TGT_W-1:0]    wait_r, wait_nxt;
  logic [SUM_W-1:0]    elapsed_r, elapsed_nxt;

  // output buffer
  logic              out_valid_r;
  lmsd_pkg::pins_t   out_word_r;
  logic              skid_valid_r;
  lmsd_pkg::pins_t   skid_word_r;

  logic in_fire, out_fire;
  logic [2:0] pixel_x;
  logic [1:0] pixel_y;
  logic [1:0] pixel_level;
  logic [1:0] in_cmd;

  lmsd_pkg::pins_t res;
  logic            res_valid;

  // state after running out of a finished wait
  lmsd_pkg::phase_t    adv_phase;
  logic [ROW_W-1:0]    adv_row;
  logic [SLICE_IW-1:0] adv_slice;
  logic [SHIFT_W-1:0]  adv_shift;
  logic [SLICE_IW:0]   slice_inc;
  logic [ROW_W:0]      row_inc;
  logic [ROW_IW-1:0]   r_idx;
  logic [SLICE_IW-1:0] s_idx;
  logic [7:0]          col_word;
  logic [SHIFT_W:0]    shift_inc;
  logic [TGT_W-1:0]    tgt;
  logic [SUM_W-1:0]    tgt_ext;

  logic            draw_en;
  logic [1:0]      lv_sat;
  logic [COLS-1:0] draw_bit;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;

  assign in_cmd      = in_tuser;
  assign pixel_x     = in_tdata[2:0];
  assign pixel_y     = in_tdata[4:3];
  assign pixel_level = in_tdata[6:5];

  assign cfg_ready  = 1'b1;
  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_word_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r[0] <= lmsd_pkg::SLICE0_RST;
      target_r[1] <= lmsd_pkg::SLICE1_RST;
      target_r[2] <= lmsd_pkg::SLICE2_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lmsd_pkg::REG_SLICE0: target_r[0] <= cfg_data;
        lmsd_pkg::REG_SLICE1: target_r[1] <= cfg_data;
        lmsd_pkg::REG_SLICE2: target_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel store
  assign draw_en  = in_fire && (in_cmd == lmsd_pkg::CMD_DRAW) &&
                    (32'(pixel_x) < COLS) && (32'(pixel_y) < ROWS);
  assign lv_sat   = (32'(pixel_level) > LEVELS) ? 2'(LEVELS) : pixel_level;
  assign draw_bit = COLS'(1) << (3'(COLS - 1) - pixel_x);

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_cmd == lmsd_pkg::CMD_CLEAR)) begin
      for (int i = 0; i < ROWS; i++) begin
        row_bits_r[i] <= '0;
        for (int j = 0; j < LEVELS; j++) begin
          slice_masks_r[i][j] <= '0;
        end
      end
    end else if (draw_en) begin
      row_bits_r[pixel_y[ROW_IW-1:0]] <= row_bits_r[pixel_y[ROW_IW-1:0]] | draw_bit;
      for (int j = 0; j < LEVELS; j++) begin
        if (j < 32'(lv_sat)) begin
          slice_masks_r[pixel_y[ROW_IW-1:0]][j] <=
            slice_masks_r[pixel_y[ROW_IW-1:0]][j] | draw_bit;
        end
      end
    end
  end

  // a finished wait falls through into the next action on the same tick
  assign slice_inc = {1'b0, slice_r} + 1'b1;
  assign row_inc   = {1'b0, row_r} + 1'b1;

  always_comb begin
    adv_phase = phase_r;
    adv_row   = row_r;
    adv_slice = slice_r;
    adv_shift = shift_r;
    if (phase_r == lmsd_pkg::PH_WAIT && wait_r == '0) begin
      if (32'(slice_inc) < LEVELS) begin
        adv_slice = slice_inc[SLICE_IW-1:0];
        adv_shift = '0;
        adv_phase = lmsd_pkg::PH_SHIFT;
      end else begin
        adv_slice = '0;
        adv_row   = row_inc[ROW_W-1:0];
        adv_phase = (32'(row_inc) < ROWS) ? lmsd_pkg::PH_ROWCLK : lmsd_pkg::PH_BLANKCLK;
      end
    end
  end

  assign r_idx     = (32'(adv_row) < ROWS) ? adv_row[ROW_IW-1:0] : '0;
  assign s_idx     = (32'(adv_slice) < LEVELS) ? adv_slice : '0;
  assign col_word  = 8'(row_bits_r[r_idx] & slice_masks_r[r_idx][s_idx]);
  assign shift_inc = {1'b0, adv_shift} + 1'b1;
  assign tgt       = target_r[s_idx];
  assign tgt_ext   = SUM_W'(tgt);

  always_comb begin
    phase_nxt   = phase_r;
    row_nxt     = row_r;
    slice_nxt   = slice_r;
    shift_nxt   = shift_r;
    wait_nxt    = wait_r;
    elapsed_nxt = elapsed_r;
    res         = '0;
    res_valid   = 1'b0;
    if (in_fire) begin
      unique case (in_cmd)
        lmsd_pkg::CMD_CLEAR: begin
          res.latch_pulse = 1'b1;
          res.clear_pulse = 1'b1;
          res_valid       = 1'b1;
        end
        lmsd_pkg::CMD_TICK: begin
          if (phase_r == lmsd_pkg::PH_WAIT && wait_r != '0) begin
            wait_nxt = wait_r - 1'b1;
          end else begin
            phase_nxt = adv_phase;
            row_nxt   = adv_row;
            slice_nxt = adv_slice;
            shift_nxt = adv_shift;
            res_valid = 1'b1;
            unique case (adv_phase)
              lmsd_pkg::PH_ROWCLK: begin
                res.row_data        = (r_idx == '0);
                res.row_clock_pulse = 1'b1;
                elapsed_nxt         = '0;
                slice_nxt           = '0;
                shift_nxt           = '0;
                phase_nxt           = lmsd_pkg::PH_SHIFT;
              end
              lmsd_pkg::PH_SHIFT: begin
                // inverted column bit, lsb first; 0 lights the led
                res.col_data        = !col_word[adv_shift];
                res.col_clock_pulse = 1'b1;
                shift_nxt           = shift_inc[SHIFT_W-1:0];
                if (32'(shift_inc) >= COLS) begin
                  phase_nxt = lmsd_pkg::PH_LATCH;
                end
              end
              lmsd_pkg::PH_LATCH: begin
                res.latch_pulse = 1'b1;
                wait_nxt        = (tgt_ext > elapsed_r) ? TGT_W'(tgt_ext - elapsed_r) : '0;
                elapsed_nxt     = elapsed_r + tgt_ext;
                phase_nxt       = lmsd_pkg::PH_WAIT;
              end
              lmsd_pkg::PH_BLANKCLK: begin
                res.row_clock_pulse = 1'b1;
                phase_nxt           = lmsd_pkg::PH_BLANKLATCH;
              end
              default: begin
                res.latch_pulse = 1'b1;
                row_nxt         = '0;
                slice_nxt       = '0;
                shift_nxt       = '0;
                phase_nxt       = lmsd_pkg::PH_ROWCLK;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lmsd_pkg::PH_ROWCLK;
      row_r     <= '0;
      slice_r   <= '0;
      shift_r   <= '0;
      wait_r    <= '0;
      elapsed_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      row_r     <= row_nxt;
      slice_r   <= slice_nxt;
      shift_r   <= shift_nxt;
      wait_r    <= wait_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // two-word output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= res_valid;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_word_r <= skid_word_r;
        if (res_valid) begin
          skid_word_r <= res;
        end
      end else if (res_valid) begin
        out_word_r <= res;
      end
    end else if (res_valid) begin
      skid_word_r <= res;
    end
  end

  // skid word only ever sits behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  // a clear word always carries the latch pulse and nothing of the scan
  a_clear_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.clear_pulse |->
      out_word_r.latch_pulse && !out_word_r.row_clock_pulse && !out_word_r.col_clock_pulse)
    else $error("malformed clear word");

  // column shifting never runs past the row width
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lmsd_pkg::PH_SHIFT |-> 32'(shift_r) < COLS)
    else $error("column shift count out of range");

  // with no input or output handshake, a held output word must stay unchanged
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire && !out_fire && out_valid_r |=> out_valid_r && $stable(out_word_r))
    else $error("output word changed without a handshake");

endmodule

[test/led_matrix_scan_dimmer_tb.sv]
// ----------------------------------------------------------------------------
// led_matrix_scan_dimmer_tb
// Self-checking bench for the LED matrix scan dimmer. Draw, clear and tick
// words go in over the input stream, and a local scan model predicts every
// pin word. Slice targets are changed between phases. The extremes are zero,
// full scale and targets that overlap, and the sender and receiver idle at
// random at several rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module led_matrix_scan_dimmer_tb;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam logic [1:0] REG_NONE     = 2'd3;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         CYCLE_LIMIT  = 1_000_000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // pixel_x[2:0], pixel_y[4:3], pixel_level[6:5], zero[7]
  logic [1:0]  in_tuser   = '0;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // row_data, row_clock, col_data, col_clock, latch, clear,
                                  // zero[7:6]

  led_matrix_scan_dimmer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // scan model state
  logic [lmsd_pkg::TGT_W-1:0] tgt [3];
  logic [lmsd_pkg::COLS-1:0]  row_store [lmsd_pkg::ROWS];
  logic [lmsd_pkg::COLS-1:0]  slice_store [lmsd_pkg::ROWS][lmsd_pkg::LEVELS];
  int unsigned                scan_row;
  int unsigned                scan_slice;
  int unsigned                shift_cnt;
  lmsd_pkg::phase_t           phase;
  logic [lmsd_pkg::TGT_W-1:0] wait_cnt;
  logic [lmsd_pkg::SUM_W-1:0] elapsed;

  lmsd_pkg::pins_t pin_q [$];
  int    err_cnt       = 0;
  int    send_idle_pct = 0;
  int    stall_pct     = 0;
  int    cycle_cnt     = 0;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  function automatic void model_reset();
    tgt[0] = lmsd_pkg::SLICE0_RST;
    tgt[1] = lmsd_pkg::SLICE1_RST;
    tgt[2] = lmsd_pkg::SLICE2_RST;
    foreach (row_store[i]) row_store[i] = '0;
    foreach (slice_store[i, j]) slice_store[i][j] = '0;
    scan_row   = 0;
    scan_slice = 0;
    shift_cnt  = 0;
    phase      = lmsd_pkg::PH_ROWCLK;
    wait_cnt   = '0;
    elapsed    = '0;
  endfunction

  // one tick: counts down a running wait, or runs through finished waits until an action makes a pin word
  function automatic void model_scan();
    int unsigned                r;
    int unsigned                s;
    logic [lmsd_pkg::COLS-1:0]  v;
    logic [lmsd_pkg::TGT_W-1:0] t;
    lmsd_pkg::pins_t            p;
    bit                         done;
    done = 1'b0;
    while (!done) begin
      r = (scan_row < lmsd_pkg::ROWS) ? scan_row : 0;
      s = (scan_slice < lmsd_pkg::LEVELS) ? scan_slice : 0;
      p = '0;
      case (phase)
        lmsd_pkg::PH_ROWCLK: begin
          p.row_data        = (r == 0);
          p.row_clock_pulse = 1'b1;
          elapsed    = '0;
          scan_slice = 0;
          shift_cnt  = 0;
          phase      = lmsd_pkg::PH_SHIFT;
          pin_q.push_back(p);
          done = 1'b1;
        end
        lmsd_pkg::PH_SHIFT: begin
          v = row_store[r] & slice_store[r][s];
          p.col_data        = ~v[shift_cnt];
          p.col_clock_pulse = 1'b1;
          shift_cnt++;
          if (shift_cnt >= lmsd_pkg::COLS) phase = lmsd_pkg::PH_LATCH;
          pin_q.push_back(p);
          done = 1'b1;
        end
        lmsd_pkg::PH_LATCH: begin
          t = tgt[s];
          p.latch_pulse = 1'b1;
          wait_cnt = (t > elapsed) ? t - elapsed[lmsd_pkg::TGT_W-1:0] : '0;
          elapsed  = elapsed + t;
          phase    = lmsd_pkg::PH_WAIT;
          pin_q.push_back(p);
          done = 1'b1;
        end
        lmsd_pkg::PH_WAIT: begin
          if (wait_cnt != 0) begin
            wait_cnt--;
            done = 1'b1;
          end else begin
            scan_slice++;
            if (scan_slice < lmsd_pkg::LEVELS) begin
              shift_cnt = 0;
              phase     = lmsd_pkg::PH_SHIFT;
            end else begin
              scan_slice = 0;
              scan_row++;
              phase = (scan_row < lmsd_pkg::ROWS) ? lmsd_pkg::PH_ROWCLK
                                                  : lmsd_pkg::PH_BLANKCLK;
            end
          end
        end
        lmsd_pkg::PH_BLANKCLK: begin
          p.row_clock_pulse = 1'b1;
          phase = lmsd_pkg::PH_BLANKLATCH;
          pin_q.push_back(p);
          done = 1'b1;
        end
        default: begin
          p.latch_pulse = 1'b1;
          scan_row   = 0;
          scan_slice = 0;
          shift_cnt  = 0;
          phase      = lmsd_pkg::PH_ROWCLK;
          pin_q.push_back(p);
          done = 1'b1;
        end
      endcase
    end
  endfunction

  function automatic void model_word(logic [1:0] cmd, logic [7:0] data);
    int unsigned               x;
    int unsigned               y;
    int unsigned               lv;
    logic [lmsd_pkg::COLS-1:0] col_bit;
    lmsd_pkg::pins_t           p;
    x  = data[2:0];
    y  = data[4:3];
    lv = data[6:5];
    case (cmd)
      lmsd_pkg::CMD_DRAW: begin
        if (x < lmsd_pkg::COLS && y < lmsd_pkg::ROWS) begin
          if (lv > lmsd_pkg::LEVELS) lv = lmsd_pkg::LEVELS;
          col_bit = '0;
          col_bit[lmsd_pkg::COLS-1-x] = 1'b1;
          row_store[y] |= col_bit;
          for (int i = 0; i < lv; i++) slice_store[y][i] |= col_bit;
        end
      end
      lmsd_pkg::CMD_CLEAR: begin
        foreach (row_store[i]) row_store[i] = '0;
        foreach (slice_store[i, j]) slice_store[i][j] = '0;
        p = '0;
        p.latch_pulse = 1'b1;
        p.clear_pulse = 1'b1;
        pin_q.push_back(p);
      end
      lmsd_pkg::CMD_TICK: model_scan();
      default: ;
    endcase
  endfunction

  task automatic check_field(string name, logic [1:0] exp_v, logic [1:0] act_v);
    if (act_v !== exp_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %b, got %b", $time, name, exp_v, act_v);
    end
  endtask

  // values are stable at the falling edge, so a word seen here lands at the next rise
  always @(negedge clk) begin
    lmsd_pkg::pins_t exp_p;
    lmsd_pkg::pins_t got_p;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got_p = out_tdata[5:0];
      if (pin_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected pin word, expected none, got %h", $time, out_tdata);
      end else begin
        exp_p = pin_q.pop_front();
        check_field("row_data", exp_p.row_data, got_p.row_data);
        check_field("row_clock_pulse", exp_p.row_clock_pulse, got_p.row_clock_pulse);
        check_field("col_data", exp_p.col_data, got_p.col_data);
        check_field("col_clock_pulse", exp_p.col_clock_pulse, got_p.col_clock_pulse);
        check_field("latch_pulse", exp_p.latch_pulse, got_p.latch_pulse);
        check_field("clear_pulse", exp_p.clear_pulse, got_p.clear_pulse);
        check_field("pad bits", 2'b00, out_tdata[7:6]);
      end
    end
  end

  // called at a rising edge, returns at the edge that takes the word
  task automatic send_word(logic [1:0] cmd, logic [7:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    model_word(cmd, data);
    @(posedge clk);
  endtask

  task automatic draw(int unsigned x, int unsigned y, int unsigned lv);
    send_word(lmsd_pkg::CMD_DRAW, {1'b0, lv[1:0], y[1:0], x[2:0]});
  endtask

  task automatic ticks(int n);
    repeat (n) send_word(lmsd_pkg::CMD_TICK, {1'b0, 7'($urandom)});
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pin_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    if (idx <= lmsd_pkg::REG_SLICE2) tgt[idx] = val;
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_word();
    int unsigned pick;
    logic [2:0]  x;
    pick = $urandom_range(0, 99);
    x    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    if (pick < 55)      send_word(lmsd_pkg::CMD_TICK, {1'b0, 7'($urandom)});
    else if (pick < 90) send_word(lmsd_pkg::CMD_DRAW, {1'b0, 2'($urandom), 2'($urandom), x});
    else if (pick < 95) send_word(lmsd_pkg::CMD_CLEAR, {1'b0, 7'($urandom)});
    else                send_word(CMD_UNUSED, {1'b0, 7'($urandom)});
  endtask

  // reset targets, pixel extremes, ignored draws and a clear inside a wait
  task automatic test_directed();
    draw(0, 0, 3);
    draw(5, 3, 3);
    draw(5, 0, 0);
    draw(2, 1, 1);
    draw(3, 2, 2);
    draw(4, 3, 1);
    draw(6, 0, 3);
    draw(7, 3, 3);
    send_word(CMD_UNUSED, 8'h7f);
    ticks(12);
    send_word(lmsd_pkg::CMD_CLEAR, 8'h7f);
    draw(1, 0, 3);
    draw(0, 1, 2);
    draw(5, 2, 1);
    draw(3, 0, 2);
    // runs through the first two slice waits and stops before the third latch
    ticks(305);
    settle();
  endtask

  task automatic test_zero_and_overlap();
    write_reg(lmsd_pkg::REG_SLICE0, 16'h0000);
    write_reg(lmsd_pkg::REG_SLICE1, 16'h0000);
    write_reg(lmsd_pkg::REG_SLICE2, 16'h0000);
    write_reg(REG_NONE, 16'hffff);
    repeat (100) random_word();
    settle();
    // later targets below the running sum give zero waits
    write_reg(lmsd_pkg::REG_SLICE0, 16'd20);
    write_reg(lmsd_pkg::REG_SLICE1, 16'd5);
    write_reg(lmsd_pkg::REG_SLICE2, 16'd40);
    repeat (100) random_word();
    settle();
  endtask

  task automatic test_full_scale();
    write_reg(lmsd_pkg::REG_SLICE0, 16'hffff);
    write_reg(lmsd_pkg::REG_SLICE1, 16'hffff);
    write_reg(lmsd_pkg::REG_SLICE2, 16'hffff);
    write_reg(REG_NONE, 16'h0000);
    draw(0, 0, 3);
    draw(2, 0, 1);
    ticks(100);
    settle();
  endtask

  task automatic test_random_pressure();
    int idle_tab [4]  = '{0, 69, 0, 13};
    int stall_tab [4] = '{0, 0, 69, 13};
    for (int m = 0; m < 4; m++) begin
      for (int r = 0; r < lmsd_pkg::LEVELS; r++)
        write_reg(r[1:0], ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 50))
                                                      : 16'($urandom_range(0, 12)));
      send_idle_pct = idle_tab[m];
      stall_pct     = stall_tab[m];
      repeat (150) random_word();
      send_idle_pct = 0;
      repeat (25) random_word();
      stall_pct = 0;
      settle();
    end
  endtask

  initial begin
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_zero_and_overlap();
    test_random_pressure();
    // last, since it leaves the scan inside a long wait
    test_full_scale();
    settle();
    if (err_cnt == 0) begin
      $display("** led_matrix_scan_dimmer: PASSED **");
    end else begin
      $display("** led_matrix_scan_dimmer: FAILED **");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: timeout, %0d pin words still expected", $time, pin_q.size());
    $display("** led_matrix_scan_dimmer: FAILED **");
    $finish;
  end

endmodule
